// ===== hw/rtl/i128alu_pkg.sv =====
// Package for the 128-bit signed ALU: operation codes and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package i128alu_pkg;
	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_MUL = 4'd2;
	localparam logic [3:0] FN_DIV = 4'd3;
	localparam logic [3:0] FN_MOD = 4'd4;
	localparam logic [3:0] FN_AND = 4'd5;
	localparam logic [3:0] FN_OR  = 4'd6;
	localparam logic [3:0] FN_XOR = 4'd7;
	localparam logic [3:0] FN_NOT = 4'd8;
	localparam logic [3:0] FN_SHL = 4'd9;
	localparam logic [3:0] FN_SAR = 4'd10;
	localparam logic [3:0] FN_ROL = 4'd11;
	localparam logic [3:0] FN_ROR = 4'd12;

	localparam int HALF_BITS = 64;
	localparam int OUT_BITS  = 128;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture operands
		logic setup;   // initialize the iteration registers
		logic step;    // one iteration of multiply or divide
		logic finish;  // form the result into the output register
	} i128alu_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic iterative; // the loaded operation needs the iteration loop
		logic last;      // the current step is the final one
	} i128alu_sts_t;
endpackage

// ===== hw/rtl/int128_signed_alu_top.sv =====
// Top level of the 128-bit signed ALU: controller plus datapath.
// Depends on i128alu_pkg, i128alu_ctrl and i128alu_dp.
//
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | func, a_high, a_low, b_high, b_low, shift_amount
// out     | output    | out_valid/out_stall| result_high, result_low, flags
//
// One item is in flight at a time. Add, subtract, logic, shifts and rotates skip the
// iteration loop; multiply and divide run the shift-add and restoring loop, one bit
// per cycle, before the result is registered, and a divide by zero skips the loop.
// The next input transfer can come once the controller is back in idle.
// Reset clears the controller and the output valid; payload is unreset.
// A stalled output holds its result; the next item can be taken once the
// result has moved into the output register.
`timescale 1ns / 1ps
module int128_signed_alu_top
	import i128alu_pkg::*;
#(
	parameter int WORD_BITS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [3:0]           func,
	input  logic [HALF_BITS-1:0] a_high,
	input  logic [HALF_BITS-1:0] a_low,
	input  logic [HALF_BITS-1:0] b_high,
	input  logic [HALF_BITS-1:0] b_low,
	input  logic [7:0]           shift_amount,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [HALF_BITS-1:0] result_high,
	output logic [HALF_BITS-1:0] result_low,
	output logic                 less_than,
	output logic                 equal_to,
	output logic                 greater_than,
	output logic                 divide_by_zero
);
	i128alu_cmd_t cmd;
	i128alu_sts_t sts;

	// The controller sequences load, iteration and result transfer.
	i128alu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	// The datapath holds operands, the iterative unit and the result register.
	i128alu_dp #(.WORD_BITS(WORD_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.func(func), .a_high(a_high), .a_low(a_low),
		.b_high(b_high), .b_low(b_low), .shift_amount(shift_amount),
		.result_high(result_high), .result_low(result_low),
		.less_than(less_than), .equal_to(equal_to),
		.greater_than(greater_than), .divide_by_zero(divide_by_zero)
	);
endmodule

// ===== hw/rtl/i128alu_ctrl.sv =====
// Controller state machine of the 128-bit signed ALU.
// Depends on i128alu_pkg.
`timescale 1ns / 1ps
module i128alu_ctrl
	import i128alu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	output i128alu_cmd_t cmd,
	input  i128alu_sts_t sts
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.setup  = (state_q == ST_LOAD);
		cmd.step   = (state_q == ST_RUN);
		cmd.finish = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= sts.iterative ? ST_RUN : ST_FIN;
				end
				ST_RUN: begin
					if (sts.last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hw/rtl/i128alu_dp.sv =====
// Datapath of the 128-bit signed ALU: operand registers, shift-add multiplier,
// restoring divider, combinational operations and the output register. Depends on i128alu_pkg.
`timescale 1ns / 1ps
module i128alu_dp
	import i128alu_pkg::*;
#(
	parameter int WORD_BITS = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i128alu_cmd_t         cmd,
	output i128alu_sts_t         sts,
	input  logic [3:0]           func,
	input  logic [HALF_BITS-1:0] a_high,
	input  logic [HALF_BITS-1:0] a_low,
	input  logic [HALF_BITS-1:0] b_high,
	input  logic [HALF_BITS-1:0] b_low,
	input  logic [7:0]           shift_amount,
	output logic [HALF_BITS-1:0] result_high,
	output logic [HALF_BITS-1:0] result_low,
	output logic                 less_than,
	output logic                 equal_to,
	output logic                 greater_than,
	output logic                 divide_by_zero
);
	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q, b_q;
	logic [3:0]    func_q;
	logic [7:0]    sh_q;
	logic [W-1:0]  acc_q;   // product accumulator or remainder
	logic [W-1:0]  opr_q;   // shifted multiplicand or dividend/quotient
	logic [W-1:0]  mb_q;    // multiplier bits or divisor magnitude
	logic [CW-1:0] cnt_q;
	logic          an_q, bn_q, dz_q;

	logic [W-1:0]  a_in, b_in;
	logic [W-1:0]  a_mag, b_mag;
	logic          is_div, is_mul;
	logic [W-1:0]  rem_sh;
	logic [W:0]    rem_diff;
	logic [W-1:0]  res;
	logic          slt_ab, slt_ba;

	assign a_in   = W'({a_high, a_low});
	assign b_in   = W'({b_high, b_low});
	assign is_div = (func_q == FN_DIV) || (func_q == FN_MOD);
	assign is_mul = (func_q == FN_MUL);
	assign a_mag  = a_q[W-1] ? (~a_q + W'(1)) : a_q;
	assign b_mag  = b_q[W-1] ? (~b_q + W'(1)) : b_q;

	assign sts.iterative = is_mul || (is_div && (b_q != '0));
	assign sts.last      = (cnt_q == CW'(W - 1));

	assign rem_sh   = {acc_q[W-2:0], opr_q[W-1]};
	assign rem_diff = {1'b0, rem_sh} - {1'b0, mb_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q    <= a_in;
			b_q    <= b_in;
			func_q <= func;
			sh_q   <= shift_amount;
		end else if (cmd.setup) begin
			// Setup cycle right after load.
			acc_q <= '0;
			an_q  <= a_q[W-1];
			bn_q  <= b_q[W-1];
			dz_q  <= is_div && (b_q == '0);
			if (is_mul) begin
				opr_q <= a_q;
				mb_q  <= b_q;
			end else begin
				opr_q <= a_mag;
				mb_q  <= b_mag;
			end
		end
		if (cmd.step) begin
			if (is_mul) begin
				if (mb_q[0]) begin
					acc_q <= acc_q + opr_q;
				end
				opr_q <= {opr_q[W-2:0], 1'b0};
				mb_q  <= {1'b0, mb_q[W-1:1]};
			end else begin
				if (!rem_diff[W]) begin
					acc_q <= rem_diff[W-1:0];
				end else begin
					acc_q <= rem_sh;
				end
				opr_q <= {opr_q[W-2:0], !rem_diff[W]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= sts.last ? '0 : cnt_q + CW'(1);
		end
	end

	always_comb begin
		res = '0;
		case (func_q)
			FN_ADD: res = a_q + b_q;
			FN_SUB: res = a_q - b_q;
			FN_MUL: res = acc_q;
			FN_DIV: res = dz_q ? '0 : ((an_q ^ bn_q) ? (~opr_q + W'(1)) : opr_q);
			FN_MOD: res = dz_q ? '0 : (an_q ? (~acc_q + W'(1)) : acc_q);
			FN_AND: res = a_q & b_q;
			FN_OR:  res = a_q | b_q;
			FN_XOR: res = a_q ^ b_q;
			FN_NOT: res = ~a_q;
			FN_SHL: res = (32'(sh_q) >= W) ? '0 : (a_q << sh_q);
			FN_SAR: res = (32'(sh_q) >= W) ? {W{a_q[W-1]}} : W'($signed(a_q) >>> sh_q);
			FN_ROL: res = {a_q[W-2:0], a_q[W-1]};
			FN_ROR: res = {a_q[0], a_q[W-1:1]};
			default: res = '0;
		endcase
	end

	assign slt_ab = $signed(a_q) < $signed(b_q);
	assign slt_ba = $signed(b_q) < $signed(a_q);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			{result_high, result_low} <= OUT_BITS'($signed(res));
			less_than      <= slt_ab;
			equal_to       <= (a_q == b_q);
			greater_than   <= slt_ba;
			divide_by_zero <= dz_q;
		end
	end
endmodule
